// ----- hdl/gcf_pkg.sv -----
package gcf_pkg;

	localparam int FIFO_DEPTH = 2;

	// configuration register indexes
	localparam logic [1:0] REG_SEND_INTERVAL = 2'd0;
	localparam logic [1:0] REG_SPEED_LIMIT   = 2'd1;

	localparam logic [15:0] SEND_INTERVAL_RST = 16'd40;
	localparam logic [6:0]  SPEED_LIMIT_RST   = 7'd100;

	localparam logic [7:0] HDR0       = 8'h55;
	localparam logic [7:0] HDR1       = 8'h66;
	localparam logic [7:0] HDR2       = 8'h01;
	localparam logic [7:0] CMD_ROTATE = 8'h07;
	localparam logic [7:0] CMD_CENTRE = 8'h08;
	localparam logic [7:0] LEN_ROTATE = 8'h02;
	localparam logic [7:0] LEN_CENTRE = 8'h01;
	localparam logic [7:0] CENTRE_ARG = 8'h01;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// bytes before the crc
	localparam logic [3:0] BODY_ROTATE = 4'd10;
	localparam logic [3:0] BODY_CENTRE = 4'd9;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_ROTATE = 2'd1,
		REQ_CENTRE = 2'd2
	} req_type_t;

	typedef struct packed {
		logic        is_rotate;
		logic [15:0] seq;
		logic [7:0]  yaw;
		logic [7:0]  pitch;
	} frame_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// crc-16/xmodem, msb first, one byte
	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- hdl/gimbal_command_framer_core.sv -----
// a command word is written into the queue, loaded into the serializer, then registered out
// one frame byte per cycle while m_tready holds; a rotate frame is 12 bytes, a centre frame 11
// ticks and commands are taken every cycle while the queue has room; early rotates are dropped
// a two-entry descriptor queue lets commands be taken while a frame is still going out
// reset clears sequence and elapsed counters, empties the queue, and restores register defaults
module gimbal_command_framer_core #(
	parameter int FIFO_DEPTH = gcf_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // yaw_speed[10:0], pitch_speed[21:11], zero pad
	input  logic [1:0]  s_tuser,    // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // frame_byte[7:0]
	output logic        m_tlast,    // frame_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	gcf_pkg::fifo_stat_t  stat;
	gcf_pkg::frame_desc_t push_desc;
	gcf_pkg::frame_desc_t pop_desc;
	logic                 push;
	logic                 pop;

	gcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.push      (push),
		.push_desc (push_desc)
	);

	gcf_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.stat      (stat)
	);

	gcf_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.desc     (pop_desc),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- hdl/gcf_front.sv -----
module gcf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // yaw_speed[10:0], pitch_speed[21:11], zero pad
	input  logic [1:0]           s_tuser,   // req_type[1:0]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  gcf_pkg::fifo_stat_t  stat,
	output logic                 push,
	output gcf_pkg::frame_desc_t push_desc
);

	logic [15:0] interval_q;
	logic [6:0]  limit_q;
	logic [15:0] seq_q;
	logic [15:0] elapsed_q;
	logic        accept;
	logic        rotate_ok;
	logic [15:0] seq_inc;
	gcf_pkg::req_type_t req;

	function automatic logic [7:0] clamp8(logic signed [10:0] v, logic [6:0] lim);
		logic signed [10:0] hi;
		logic signed [10:0] lo;
		logic signed [10:0] r;
		hi = $signed({4'b0000, lim});
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[7:0];
	endfunction

	assign s_tready  = !stat.full;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign req       = gcf_pkg::req_type_t'(s_tuser);
	assign rotate_ok = elapsed_q >= interval_q;
	assign seq_inc   = seq_q + 16'd1;

	always_comb begin
		push = 1'b0;
		unique case (req)
			gcf_pkg::REQ_ROTATE: push = accept && rotate_ok;
			gcf_pkg::REQ_CENTRE: push = accept;
			default:             push = 1'b0;
		endcase
		push_desc.is_rotate = (req == gcf_pkg::REQ_ROTATE);
		push_desc.seq       = seq_inc;
		push_desc.yaw       = clamp8($signed(s_tdata[10:0]), limit_q);
		push_desc.pitch     = clamp8($signed(s_tdata[21:11]), limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= gcf_pkg::SEND_INTERVAL_RST;
			limit_q    <= gcf_pkg::SPEED_LIMIT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == gcf_pkg::REG_SEND_INTERVAL) begin
				interval_q <= cfg_data;
			end else if (cfg_index == gcf_pkg::REG_SPEED_LIMIT) begin
				limit_q <= cfg_data[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= '0;
			elapsed_q <= '0;
		end else begin
			if (push) begin
				seq_q <= seq_inc;
			end
			if (accept) begin
				unique case (req)
					gcf_pkg::REQ_TICK: begin
						if (elapsed_q != 16'hFFFF) begin
							elapsed_q <= elapsed_q + 16'd1;
						end
					end
					gcf_pkg::REQ_ROTATE: begin
						if (rotate_ok) begin
							elapsed_q <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- hdl/gcf_fifo.sv -----
module gcf_fifo #(
	parameter int DEPTH = gcf_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  gcf_pkg::frame_desc_t push_desc,
	input  logic                 pop,
	output gcf_pkg::frame_desc_t pop_desc,
	output gcf_pkg::fifo_stat_t  stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	gcf_pkg::frame_desc_t mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign pop_desc   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full && !pop |-> !push) else $error("descriptor queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop) else $error("descriptor queue underflow");

endmodule

// ----- hdl/gcf_serializer.sv -----
module gcf_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gcf_pkg::fifo_stat_t  stat,
	input  gcf_pkg::frame_desc_t desc,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // frame_byte[7:0]
	output logic                 m_tlast    // frame_last
);

	gcf_pkg::frame_desc_t desc_q;
	logic        busy_q;
	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_last_q;

	logic        slot_free;
	logic        emit;
	logic [3:0]  body_len;
	logic [7:0]  body_byte;
	logic [7:0]  next_byte;
	logic        next_last;
	logic        in_body;

	assign slot_free = !out_valid_q || m_tready;
	assign emit      = busy_q && slot_free;
	assign body_len  = desc_q.is_rotate ? gcf_pkg::BODY_ROTATE : gcf_pkg::BODY_CENTRE;
	assign in_body   = idx_q < body_len;
	// next frame loads when idle, or in the same cycle that the last byte is registered into the output slot
	assign pop       = !stat.empty && (!busy_q || (emit && next_last));

	always_comb begin
		body_byte = 8'h00;
		unique case (idx_q)
			4'd0: body_byte = gcf_pkg::HDR0;
			4'd1: body_byte = gcf_pkg::HDR1;
			4'd2: body_byte = gcf_pkg::HDR2;
			4'd3: body_byte = desc_q.is_rotate ? gcf_pkg::LEN_ROTATE : gcf_pkg::LEN_CENTRE;
			4'd4: body_byte = 8'h00;
			4'd5: body_byte = desc_q.seq[7:0];
			4'd6: body_byte = desc_q.seq[15:8];
			4'd7: body_byte = desc_q.is_rotate ? gcf_pkg::CMD_ROTATE : gcf_pkg::CMD_CENTRE;
			4'd8: body_byte = desc_q.is_rotate ? desc_q.yaw : gcf_pkg::CENTRE_ARG;
			4'd9: body_byte = desc_q.pitch;
			default: body_byte = 8'h00;
		endcase
	end

	always_comb begin
		next_last = 1'b0;
		if (in_body) begin
			next_byte = body_byte;
		end else if (idx_q == body_len) begin
			next_byte = crc_q[7:0];
		end else begin
			next_byte = crc_q[15:8];
			next_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= desc;
		end
		if (emit) begin
			out_data_q <= next_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				crc_q  <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 4'd1;
				if (next_last) begin
					busy_q <= 1'b0;
				end
			end
			if (emit && in_body && !pop) begin
				crc_q <= gcf_pkg::crc_byte(crc_q, body_byte);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_last_q  <= next_last;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= body_len + 4'd1) else $error("byte index past frame end");

	a_load_at_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		pop && busy_q |-> emit && next_last) else $error("frame reloaded mid-frame");

endmodule
